/* src/mdb_pkg.sv */
package mdb_pkg;

  // Width of the edge_count register and its address decode.
  localparam int CountWidth = 7;
  localparam int AddrWidth = 3;
  localparam int DataWidth = 32;
  localparam int RegEdgeCount = 0;

  // Input command codes.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Shift applied to a product before it is accumulated.
  typedef enum logic [1:0] {
    SH_NONE,
    SH_HALF_X2,
    SH_FULL
  } prod_shift_t;

  // Query sequencer.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_TT1,
    ST_TT2,
    ST_TT3,
    ST_DT1,
    ST_DT2,
    ST_DT3,
    ST_CR1,
    ST_CR2,
    ST_CR3,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_SQ4,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_ROOT,
    ST_OUT
  } state_t;

  // Root unit sequencer.
  typedef enum logic [1:0] {
    R_IDLE,
    R_SAT,
    R_ITER
  } root_state_t;

endpackage

/* src/mdb_in_if.sv */
interface mdb_in_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic         cmd;
  logic [5:0]   edge_index;
  logic [W-1:0] start_x;
  logic [W-1:0] start_y;
  logic [W-1:0] end_x;
  logic [W-1:0] end_y;
  logic         on_boundary;
  logic [W-1:0] point_x;
  logic [W-1:0] point_y;

  modport source (
    output valid, cmd, edge_index, start_x, start_y, end_x, end_y, on_boundary,
           point_x, point_y,
    input ready
  );
  modport sink (
    input valid, cmd, edge_index, start_x, start_y, end_x, end_y, on_boundary,
          point_x, point_y,
    output ready
  );
endinterface

/* src/mdb_out_if.sv */
interface mdb_out_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] neg_distance;
  logic         no_boundary;

  modport source (
    output valid, neg_distance, no_boundary,
    input ready
  );
  modport sink (
    input valid, neg_distance, no_boundary,
    output ready
  );
endinterface

/* src/mdb_cell.sv */
module mdb_cell #(
  parameter int EW = 129
) (
  input  logic          clk,
  input  logic          shift,
  input  logic [EW-1:0] nb_edge,
  input  logic          wr_en,
  input  logic [EW-1:0] wr_edge,
  output logic [EW-1:0] edge_q
);

  // One edge entry: loaded by a write, or takes its neighbor's entry on a shift.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      edge_q <= wr_edge;
    end else if (shift) begin
      edge_q <= nb_edge;
    end
  end

endmodule

/* src/mdb_root.sv */
module mdb_root #(
  parameter int W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [4*W+3:0]    num,
  input  logic [2*W+1:0]    den,
  output logic              done,
  output logic [W-1:0]      root
);
  import mdb_pkg::*;

  localparam int H = W + 1;
  localparam int NW = 4 * H;
  localparam int RW = 4 * H + 2;
  localparam int BW = $clog2(W);

  root_state_t   rstate;
  logic [NW-1:0] num_r;
  logic [2*H-1:0] den_r;
  logic [RW-1:0] acc;
  logic [RW-1:0] qsh;
  logic [RW-1:0] dsh;
  logic [BW-1:0] bit_idx;
  logic [RW-1:0] trial;
  logic [RW-1:0] sat_val;

  // Trial square for the current bit: acc + 2^(b+1)*d*den + 2^(2b)*den.
  assign trial = acc + qsh + dsh;
  assign sat_val = RW'(den_r) << (2 * W - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      rstate <= R_IDLE;
      done <= 1'b0;
    end else begin
      case (rstate)
        R_IDLE: begin
          done <= 1'b0;
          if (start) begin
            num_r <= num;
            den_r <= den;
            rstate <= R_SAT;
          end
        end
        R_SAT: begin
          // A root at or above the clamp value needs no digit steps.
          if (sat_val <= RW'(num_r)) begin
            root <= W'(1) << (W - 1);
            done <= 1'b1;
            rstate <= R_IDLE;
          end else begin
            done <= 1'b0;
            root <= '0;
            acc <= '0;
            qsh <= '0;
            dsh <= RW'(den_r) << (2 * W - 4);
            bit_idx <= BW'(W - 2);
            rstate <= R_ITER;
          end
        end
        R_ITER: begin
          // One result bit per cycle, from the top down.
          if (trial <= RW'(num_r)) begin
            acc <= trial;
            qsh <= (qsh >> 1) + dsh;
            root[bit_idx] <= 1'b1;
          end else begin
            qsh <= qsh >> 1;
          end
          dsh <= dsh >> 2;
          bit_idx <= bit_idx - BW'(1);
          done <= (bit_idx == '0);
          if (bit_idx == '0) begin
            rstate <= R_IDLE;
          end
        end
        default: begin
          done <= 1'b0;
          rstate <= R_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/min_distance_to_boundary_segments.sv */
// Returns minus the smallest distance from a query point to the boundary edges
// held in a table of MAX_EDGES entries; a write word stores one edge, a query
// word yields one result word. Edges live in a ring of cells that rotates once
// per query, so cell 0 always presents the edge under test. A slot that is not
// a boundary edge below edge_count is passed over in the scan; a scanned
// boundary edge goes through the shared multiplier sequence and the square-root
// unit, which resolves one result bit per cycle. A query ends by loading the
// result word. edge_count is register 0 on the APB port.
module min_distance_to_boundary_segments #(
  parameter int MAX_EDGES = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  mdb_in_if.sink                        in_ch,
  mdb_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mdb_pkg::AddrWidth-1:0] paddr,
  input  logic [mdb_pkg::DataWidth-1:0] pwdata,
  output logic [mdb_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);
  import mdb_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int H = W + 1;
  localparam int EW = 4 * W + 1;
  localparam int AW = 4 * H + 1;
  localparam int KW = $clog2(MAX_EDGES + 1);
  localparam int CMPW = (KW > CountWidth) ? KW : CountWidth;

  // Configuration register.
  logic [CountWidth-1:0] edge_count;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(RegEdgeCount));
  assign prdata = (paddr[2] == 1'(RegEdgeCount)) ? DataWidth'(edge_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
    end else if (cfg_wr) begin
      edge_count <= pwdata[CountWidth-1:0];
    end
  end

  state_t state;
  state_t state_next;

  logic in_fire;
  logic wr_fire;
  logic ring_shift;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign wr_fire = in_fire && (in_ch.cmd == CMD_WRITE);

  // Ring of edge cells; cell 0 is the head, each cell takes its upper neighbor.
  logic [EW-1:0] cell_q [MAX_EDGES];
  logic [EW-1:0] wr_edge;

  assign wr_edge = {in_ch.on_boundary, in_ch.end_y, in_ch.end_x, in_ch.start_y,
                    in_ch.start_x};

  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
    mdb_cell #(.EW(EW)) u_cell (
      .clk     (clk),
      .shift   (ring_shift),
      .nb_edge (cell_q[(i + 1) % MAX_EDGES]),
      .wr_en   (wr_fire && (int'(in_ch.edge_index) == i)),
      .wr_edge (wr_edge),
      .edge_q  (cell_q[i])
    );
  end

  logic [W-1:0] head_sx, head_sy, head_ex, head_ey;
  logic         head_flag;

  assign head_sx = cell_q[0][W-1:0];
  assign head_sy = cell_q[0][2*W-1:W];
  assign head_ex = cell_q[0][3*W-1:2*W];
  assign head_ey = cell_q[0][4*W-1:3*W];
  assign head_flag = cell_q[0][4*W];

  // Query state.
  logic [W-1:0]  px, py;
  logic [KW-1:0] k;
  logic [W-1:0]  best;
  logic          found;
  logic          last_slot;
  logic          slot_live;

  assign last_slot = (k == KW'(MAX_EDGES - 1));
  assign slot_live = (CMPW'(k) < CMPW'(edge_count)) && head_flag;

  // Difference magnitudes and signs of the edge under test.
  logic [H-1:0] txm, tym, rxm, rym, fxm, fym;
  logic         txs, tys, rxs, rys;
  logic         pd_far;

  function automatic logic [H:0] diff_ms(input logic [W-1:0] a, input logic [W-1:0] b);
    logic signed [H-1:0] d;
    logic [H-1:0]        m;
    d = $signed({a[W-1], a}) - $signed({b[W-1], b});
    m = d[H-1] ? H'(-d) : H'(d);
    return {d[H-1], m};
  endfunction

  // Shared multiplier with registered product.
  logic [H-1:0]   mul_a, mul_b;
  logic           mul_neg;
  prod_shift_t    mul_sh;
  logic [2*H-1:0] prod_mag;
  logic           prod_neg;
  prod_shift_t    prod_sh;

  always_ff @(posedge clk) begin
    prod_mag <= mul_a * mul_b;
    prod_neg <= mul_neg;
    prod_sh <= mul_sh;
  end

  // Signed accumulator of shifted products.
  logic signed [AW-1:0] acc;
  logic [AW-1:0]        tmag;
  logic signed [AW-1:0] term;
  logic signed [AW-1:0] acc_sum;
  logic [2*H-1:0]       tt_r;
  logic [2*H-1:0]       crm;
  logic [H-1:0]         cr_hi, cr_lo;

  always_comb begin
    case (prod_sh)
      SH_HALF_X2: tmag = AW'(prod_mag) << (H + 1);
      SH_FULL:    tmag = AW'(prod_mag) << (2 * H);
      default:    tmag = AW'(prod_mag);
    endcase
    term = prod_neg ? -$signed(tmag) : $signed(tmag);
  end

  assign acc_sum = acc + term;
  assign cr_hi = crm[2*H-1:H];
  assign cr_lo = crm[H-1:0];

  // Operand selection for each multiply step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_neg = 1'b0;
    mul_sh = SH_NONE;
    case (state)
      ST_TT1: begin
        mul_a = txm;
        mul_b = txm;
      end
      ST_TT2: begin
        mul_a = tym;
        mul_b = tym;
      end
      ST_DT1: begin
        mul_a = rxm;
        mul_b = txm;
        mul_neg = rxs ^ txs;
      end
      ST_DT2: begin
        mul_a = rym;
        mul_b = tym;
        mul_neg = rys ^ tys;
      end
      ST_CR1: begin
        mul_a = rxm;
        mul_b = tym;
        mul_neg = rxs ^ tys;
      end
      ST_CR2: begin
        mul_a = rym;
        mul_b = txm;
        mul_neg = !(rys ^ txs);
      end
      ST_SQ1: begin
        mul_a = cr_hi;
        mul_b = cr_hi;
        mul_sh = SH_FULL;
      end
      ST_SQ2: begin
        mul_a = cr_hi;
        mul_b = cr_lo;
        mul_sh = SH_HALF_X2;
      end
      ST_SQ3: begin
        mul_a = cr_lo;
        mul_b = cr_lo;
      end
      ST_P1: begin
        mul_a = pd_far ? fxm : rxm;
        mul_b = pd_far ? fxm : rxm;
      end
      ST_P2: begin
        mul_a = pd_far ? fym : rym;
        mul_b = pd_far ? fym : rym;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Square-root unit.
  logic              root_start;
  logic [4*H-1:0]    root_num;
  logic [2*H-1:0]    root_den;
  logic              root_done;
  logic [W-1:0]      root_val;

  assign root_start = (state == ST_SQ4) || (state == ST_P3);
  assign root_num = acc_sum[4*H-1:0];
  assign root_den = (state == ST_SQ4) ? tt_r : (2*H)'(1);

  mdb_root #(.W(W)) u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .num   (root_num),
    .den   (root_den),
    .done  (root_done),
    .root  (root_val)
  );

  // Result register.
  logic out_load;

  assign out_load = (state == ST_OUT) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.neg_distance <= W'(0) - best;
      out_ch.no_boundary <= !found;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and ring rotation.
  always_comb begin
    state_next = state;
    ring_shift = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire && (in_ch.cmd == CMD_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (slot_live) begin
          state_next = ST_LOAD;
        end else begin
          ring_shift = 1'b1;
          state_next = last_slot ? ST_OUT : ST_SCAN;
        end
      end
      ST_LOAD: state_next = ST_TT1;
      ST_TT1:  state_next = ST_TT2;
      ST_TT2:  state_next = ST_TT3;
      ST_TT3:  state_next = (acc_sum == '0) ? ST_P1 : ST_DT1;
      ST_DT1:  state_next = ST_DT2;
      ST_DT2:  state_next = ST_DT3;
      ST_DT3: begin
        if (acc_sum < 0 || $unsigned(acc_sum) > AW'(tt_r)) begin
          state_next = ST_P1;
        end else begin
          state_next = ST_CR1;
        end
      end
      ST_CR1:  state_next = ST_CR2;
      ST_CR2:  state_next = ST_CR3;
      ST_CR3:  state_next = ST_SQ0;
      ST_SQ0:  state_next = ST_SQ1;
      ST_SQ1:  state_next = ST_SQ2;
      ST_SQ2:  state_next = ST_SQ3;
      ST_SQ3:  state_next = ST_SQ4;
      ST_SQ4:  state_next = ST_ROOT;
      ST_P1:   state_next = ST_P2;
      ST_P2:   state_next = ST_P3;
      ST_P3:   state_next = ST_ROOT;
      ST_ROOT: begin
        if (root_done) begin
          ring_shift = 1'b1;
          state_next = last_slot ? ST_OUT : ST_SCAN;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers of the query.
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      found <= 1'b0;
    end else begin
      if (state == ST_IDLE && in_fire && (in_ch.cmd == CMD_QUERY)) begin
        k <= '0;
        found <= 1'b0;
      end else if (ring_shift) begin
        k <= k + KW'(1);
      end
      if (state == ST_ROOT && root_done) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        px <= in_ch.point_x;
        py <= in_ch.point_y;
        best <= W'(1) << (W - 1);
      end
      ST_LOAD: begin
        {txs, txm} <= diff_ms(head_ex, head_sx);
        {tys, tym} <= diff_ms(head_ey, head_sy);
        {rxs, rxm} <= diff_ms(px, head_sx);
        {rys, rym} <= diff_ms(py, head_sy);
        fxm <= H'(diff_ms(px, head_ex));
        fym <= H'(diff_ms(py, head_ey));
        pd_far <= 1'b0;
      end
      ST_TT2, ST_DT2, ST_CR2, ST_SQ2, ST_P2: acc <= term;
      ST_TT3: tt_r <= acc_sum[2*H-1:0];
      ST_DT3: pd_far <= (acc_sum >= 0);
      ST_CR3, ST_SQ3: acc <= acc_sum;
      ST_SQ0: crm <= acc[AW-1] ? (2*H)'(-acc) : acc[2*H-1:0];
      ST_ROOT: begin
        if (root_done && (root_val < best)) begin
          best <= root_val;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule
